// ===== rtl/core/fccp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fccp_pkg;

    // Fixed Q16.16 formats of the contact fields.
    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int COEF_W      = 21;
    localparam int DIVISOR_W   = DATA_W - 1;
    localparam int DIV_W       = DATA_W + FRAC_W;
    localparam int PROD_W      = COEF_W + DIVISOR_W;
    localparam int PP_HALF_W   = PROD_W / 2;
    localparam int SQUARE_W    = 2 * PROD_W;
    localparam int MRN_W       = 2 * DATA_W;
    localparam int ROOT_W      = MRN_W / 2;
    localparam int ROOT_REM_W  = ROOT_W + 1;
    localparam int SCALE_W     = DATA_W + 2;
    localparam int SCALE_SPLIT = SCALE_W - FRAC_W;
    localparam int SCALED_W    = DATA_W + SCALE_W;
    localparam int LANES       = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [1:0] {
        MODE_SEPARATED = 2'd0,
        MODE_STICK     = 2'd1,
        MODE_SLIP      = 2'd2
    } fccp_mode_t;

    // One classified contact as it waits in the queue.
    typedef struct packed {
        logic                 drop;
        logic                 bad;
        logic                 neg_a;
        logic                 neg_b;
        logic [DATA_W-1:0]    mag_n;
        logic [DATA_W-1:0]    mag_a;
        logic [DATA_W-1:0]    mag_b;
        logic [DIVISOR_W-1:0] div_n;
        logic [DIVISOR_W-1:0] div_a;
        logic [DIVISOR_W-1:0] div_b;
    } fccp_item_t;

    // Working context of one contact in the back pipeline.
    typedef struct packed {
        logic                 drop;
        logic                 bad;
        logic                 neg_a;
        logic                 neg_b;
        logic                 slip;
        logic [DIVISOR_W-1:0] z_n;
        logic [DATA_W-1:0]    mag_a;
        logic [DATA_W-1:0]    mag_b;
        logic [PROD_W-1:0]    p;
        logic [MRN_W-1:0]     mrn;
    } fccp_ctx_t;

endpackage

`default_nettype wire

// ===== rtl/core/fccp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fccp_front (
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [fccp_pkg::DATA_W-1:0]   rhs_normal,
    input  logic signed [fccp_pkg::DATA_W-1:0]   rhs_tangent_a,
    input  logic signed [fccp_pkg::DATA_W-1:0]   rhs_tangent_b,
    input  logic signed [fccp_pkg::DATA_W-1:0]   diag_normal,
    input  logic signed [fccp_pkg::DATA_W-1:0]   diag_tangent_a,
    input  logic signed [fccp_pkg::DATA_W-1:0]   diag_tangent_b,
    input  logic                                 queue_full,
    output logic                                 push,
    output fccp_pkg::fccp_item_t                 push_item
);

    logic separated;
    logic bad_diag;

    // A positive normal value means the contact opens; diagonals are then ignored.
    assign separated = !rhs_normal[fccp_pkg::DATA_W-1] && (rhs_normal != '0);
    assign bad_diag  = !separated
                       && (diag_normal[fccp_pkg::DATA_W-1] || (diag_normal == '0)
                           || diag_tangent_a[fccp_pkg::DATA_W-1] || (diag_tangent_a == '0)
                           || diag_tangent_b[fccp_pkg::DATA_W-1] || (diag_tangent_b == '0));

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_item.drop  = separated || bad_diag;
        push_item.bad   = bad_diag;
        push_item.neg_a = !rhs_tangent_a[fccp_pkg::DATA_W-1] && (rhs_tangent_a != '0);
        push_item.neg_b = !rhs_tangent_b[fccp_pkg::DATA_W-1] && (rhs_tangent_b != '0);
        push_item.mag_n = -rhs_normal;
        push_item.mag_a = rhs_tangent_a[fccp_pkg::DATA_W-1] ? -rhs_tangent_a : rhs_tangent_a;
        push_item.mag_b = rhs_tangent_b[fccp_pkg::DATA_W-1] ? -rhs_tangent_b : rhs_tangent_b;
        push_item.div_n = diag_normal[fccp_pkg::DIVISOR_W-1:0];
        push_item.div_a = diag_tangent_a[fccp_pkg::DIVISOR_W-1:0];
        push_item.div_b = diag_tangent_b[fccp_pkg::DIVISOR_W-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/core/fccp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fccp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  fccp_pkg::fccp_item_t  push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output fccp_pkg::fccp_item_t  head_item
);

    localparam logic [fccp_pkg::QUEUE_AW:0] DEPTH_C =
        (fccp_pkg::QUEUE_AW + 1)'(fccp_pkg::QUEUE_DEPTH);

    fccp_pkg::fccp_item_t          entry_reg [fccp_pkg::QUEUE_DEPTH];
    logic [fccp_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [fccp_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [fccp_pkg::QUEUE_AW:0]   count_reg;
    logic [fccp_pkg::QUEUE_AW:0]   count_next;

    assign full      = (count_reg == DEPTH_C);
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fccp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fccp_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [fccp_pkg::COEF_W-1:0]         coef,
    input  logic                                queue_empty,
    input  fccp_pkg::fccp_item_t                head_item,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [fccp_pkg::DATA_W-1:0]  force_normal,
    output logic signed [fccp_pkg::DATA_W-1:0]  force_tangent_a,
    output logic signed [fccp_pkg::DATA_W-1:0]  force_tangent_b,
    output fccp_pkg::fccp_mode_t                contact_mode,
    output logic                                bad_diagonal
);

    localparam logic [fccp_pkg::DIV_W-1:0] DIV_LIM_NEG =
        fccp_pkg::DIV_W'(1) << (fccp_pkg::DATA_W - 1);
    localparam logic [fccp_pkg::DIV_W-1:0] DIV_LIM_POS = DIV_LIM_NEG - 1'b1;
    localparam logic [fccp_pkg::SCALE_W-1:0] SAT_NEG =
        fccp_pkg::SCALE_W'(1) << (fccp_pkg::DATA_W - 1);
    localparam logic [fccp_pkg::SCALE_W-1:0] SAT_POS = SAT_NEG - 1'b1;

    function automatic logic [fccp_pkg::DATA_W-1:0] lane_mag(
        input fccp_pkg::fccp_item_t it, input int lane);
        logic [fccp_pkg::DATA_W-1:0] m;
        begin
            case (lane)
                0:       m = it.mag_n;
                1:       m = it.mag_a;
                default: m = it.mag_b;
            endcase
            lane_mag = m;
        end
    endfunction

    function automatic logic [fccp_pkg::DIVISOR_W-1:0] lane_div(
        input fccp_pkg::fccp_item_t it, input int lane);
        logic [fccp_pkg::DIVISOR_W-1:0] d;
        begin
            case (lane)
                0:       d = it.div_n;
                1:       d = it.div_a;
                default: d = it.div_b;
            endcase
            lane_div = d;
        end
    endfunction

    // Magnitude of a saturated quotient, given the sign it will carry.
    function automatic logic [fccp_pkg::DATA_W-1:0] clamp_mag(
        input logic neg, input logic [fccp_pkg::DIV_W-1:0] q);
        logic [fccp_pkg::DIV_W-1:0] lim;
        begin
            lim       = neg ? DIV_LIM_NEG : DIV_LIM_POS;
            clamp_mag = (q > lim) ? lim[fccp_pkg::DATA_W-1:0] : q[fccp_pkg::DATA_W-1:0];
        end
    endfunction

    // Sign and magnitude to a saturated two's complement word.
    function automatic logic [fccp_pkg::DATA_W-1:0] sat_pack(
        input logic neg, input logic [fccp_pkg::SCALE_W-1:0] mag);
        logic [fccp_pkg::SCALE_W-1:0] lim;
        logic [fccp_pkg::SCALE_W-1:0] mag_c;
        begin
            lim      = neg ? SAT_NEG : SAT_POS;
            mag_c    = (mag > lim) ? lim : mag;
            sat_pack = neg ? -mag_c[fccp_pkg::DATA_W-1:0] : mag_c[fccp_pkg::DATA_W-1:0];
        end
    endfunction

    logic adv;

    // The whole pipeline moves whenever the result register can take a value.
    assign adv = !out_valid || out_ready;
    assign pop = adv && !queue_empty;

    // Three restoring dividers, one quotient bit per stage.
    logic                             dv_valid_reg [1:fccp_pkg::DIV_W];
    fccp_pkg::fccp_item_t             dv_item_reg  [1:fccp_pkg::DIV_W];
    logic [fccp_pkg::DIVISOR_W-1:0]   dv_rem_reg   [1:fccp_pkg::DIV_W][fccp_pkg::LANES];
    logic [fccp_pkg::DIV_W-1:0]       dv_dq_reg    [1:fccp_pkg::DIV_W][fccp_pkg::LANES];

    for (genvar k = 0; k < fccp_pkg::DIV_W; k++)
    begin : g_div
        logic                           valid_in;
        fccp_pkg::fccp_item_t           item_in;
        logic [fccp_pkg::DIVISOR_W-1:0] rem_in [fccp_pkg::LANES];
        logic [fccp_pkg::DIV_W-1:0]     dq_in  [fccp_pkg::LANES];

        if (k == 0)
        begin : g_first
            assign valid_in = !queue_empty;
            assign item_in  = head_item;
            for (genvar l = 0; l < fccp_pkg::LANES; l++)
            begin : g_init
                assign rem_in[l] = '0;
                assign dq_in[l]  = {lane_mag(head_item, l), {fccp_pkg::FRAC_W{1'b0}}};
            end
        end
        else
        begin : g_rest
            assign valid_in = dv_valid_reg[k];
            assign item_in  = dv_item_reg[k];
            for (genvar l = 0; l < fccp_pkg::LANES; l++)
            begin : g_take
                assign rem_in[l] = dv_rem_reg[k][l];
                assign dq_in[l]  = dv_dq_reg[k][l];
            end
        end

        for (genvar l = 0; l < fccp_pkg::LANES; l++)
        begin : g_lane
            logic [fccp_pkg::DIVISOR_W:0] trial;
            logic [fccp_pkg::DIVISOR_W:0] diff;
            logic                         fits;

            assign trial = {rem_in[l], dq_in[l][fccp_pkg::DIV_W-1]};
            assign diff  = trial - {1'b0, lane_div(item_in, l)};
            assign fits  = (trial >= {1'b0, lane_div(item_in, l)});

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_rem_reg[k+1][l] <= fits ? diff[fccp_pkg::DIVISOR_W-1:0]
                                               : trial[fccp_pkg::DIVISOR_W-1:0];
                    dv_dq_reg[k+1][l]  <= {dq_in[l][fccp_pkg::DIV_W-2:0], fits};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[k+1] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_item_reg[k+1] <= item_in;
            end
        end
    end

    // Saturation, products, sums and the cone test.
    fccp_pkg::fccp_ctx_t            ctx_a_next, ctx_a_reg;
    fccp_pkg::fccp_ctx_t            ctx_b_next, ctx_b_reg;
    fccp_pkg::fccp_ctx_t            ctx_c_next, ctx_c_reg;
    fccp_pkg::fccp_ctx_t            ctx_d_reg;
    fccp_pkg::fccp_ctx_t            ctx_e_next, ctx_e_reg;
    logic                           valid_a_reg, valid_b_reg, valid_c_reg;
    logic                           valid_d_reg, valid_e_reg;
    logic [fccp_pkg::DATA_W-1:0]    zn_mag;
    logic [fccp_pkg::PROD_W-1:0]    p_next;
    logic [fccp_pkg::MRN_W-1:0]     sqr_a_next, sqr_a_reg, sqr_b_next, sqr_b_reg;
    logic [fccp_pkg::PROD_W-1:0]    pp_hh_next, pp_hh_reg, pp_hl_next, pp_hl_reg;
    logic [fccp_pkg::PROD_W-1:0]    pp_ll_next, pp_ll_reg;
    logic [fccp_pkg::SQUARE_W-1:0]  p2_next, p2_reg;

    assign zn_mag = clamp_mag(1'b0, dv_dq_reg[fccp_pkg::DIV_W][0]);

    always_comb
    begin
        ctx_a_next       = '0;
        ctx_a_next.drop  = dv_item_reg[fccp_pkg::DIV_W].drop;
        ctx_a_next.bad   = dv_item_reg[fccp_pkg::DIV_W].bad;
        ctx_a_next.neg_a = dv_item_reg[fccp_pkg::DIV_W].neg_a;
        ctx_a_next.neg_b = dv_item_reg[fccp_pkg::DIV_W].neg_b;
        ctx_a_next.z_n   = zn_mag[fccp_pkg::DIVISOR_W-1:0];
        ctx_a_next.mag_a = clamp_mag(dv_item_reg[fccp_pkg::DIV_W].neg_a,
                                     dv_dq_reg[fccp_pkg::DIV_W][1]);
        ctx_a_next.mag_b = clamp_mag(dv_item_reg[fccp_pkg::DIV_W].neg_b,
                                     dv_dq_reg[fccp_pkg::DIV_W][2]);
    end

    assign p_next     = coef * ctx_a_reg.z_n;
    assign sqr_a_next = ctx_a_reg.mag_a * ctx_a_reg.mag_a;
    assign sqr_b_next = ctx_a_reg.mag_b * ctx_a_reg.mag_b;

    always_comb
    begin
        ctx_b_next   = ctx_a_reg;
        ctx_b_next.p = p_next;
    end

    // The square of p is split into half-width partial products.
    assign pp_hh_next = ctx_b_reg.p[fccp_pkg::PROD_W-1:fccp_pkg::PP_HALF_W]
                        * ctx_b_reg.p[fccp_pkg::PROD_W-1:fccp_pkg::PP_HALF_W];
    assign pp_hl_next = ctx_b_reg.p[fccp_pkg::PROD_W-1:fccp_pkg::PP_HALF_W]
                        * ctx_b_reg.p[fccp_pkg::PP_HALF_W-1:0];
    assign pp_ll_next = ctx_b_reg.p[fccp_pkg::PP_HALF_W-1:0]
                        * ctx_b_reg.p[fccp_pkg::PP_HALF_W-1:0];

    always_comb
    begin
        ctx_c_next     = ctx_b_reg;
        ctx_c_next.mrn = sqr_a_reg + sqr_b_reg;
    end

    assign p2_next = (fccp_pkg::SQUARE_W'(pp_hh_reg) << (2 * fccp_pkg::PP_HALF_W))
                     + (fccp_pkg::SQUARE_W'(pp_hl_reg) << (fccp_pkg::PP_HALF_W + 1))
                     + fccp_pkg::SQUARE_W'(pp_ll_reg);

    always_comb
    begin
        ctx_e_next      = ctx_d_reg;
        ctx_e_next.slip = (fccp_pkg::SQUARE_W'(ctx_d_reg.mrn) << fccp_pkg::DATA_W) > p2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_a_reg <= dv_valid_reg[fccp_pkg::DIV_W];
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
            valid_e_reg <= valid_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_a_reg <= ctx_a_next;
            ctx_b_reg <= ctx_b_next;
            sqr_a_reg <= sqr_a_next;
            sqr_b_reg <= sqr_b_next;
            ctx_c_reg <= ctx_c_next;
            pp_hh_reg <= pp_hh_next;
            pp_hl_reg <= pp_hl_next;
            pp_ll_reg <= pp_ll_next;
            ctx_d_reg <= ctx_c_reg;
            p2_reg    <= p2_next;
            ctx_e_reg <= ctx_e_next;
        end
    end

    // Digit-by-digit square root of the tangential norm, one root bit per stage.
    logic                             rt_valid_reg [1:fccp_pkg::ROOT_W];
    fccp_pkg::fccp_ctx_t              rt_ctx_reg   [1:fccp_pkg::ROOT_W];
    logic [fccp_pkg::ROOT_REM_W-1:0]  rt_rem_reg   [1:fccp_pkg::ROOT_W];
    logic [fccp_pkg::ROOT_W-1:0]      rt_root_reg  [1:fccp_pkg::ROOT_W];
    logic [fccp_pkg::MRN_W-1:0]       rt_x_reg     [1:fccp_pkg::ROOT_W];

    for (genvar k = 0; k < fccp_pkg::ROOT_W; k++)
    begin : g_root
        logic                              valid_in;
        fccp_pkg::fccp_ctx_t               ctx_in;
        logic [fccp_pkg::ROOT_REM_W-1:0]   rem_in;
        logic [fccp_pkg::ROOT_W-1:0]       root_in;
        logic [fccp_pkg::MRN_W-1:0]        x_in;
        logic [fccp_pkg::ROOT_REM_W+1:0]   rem2;
        logic [fccp_pkg::ROOT_REM_W+1:0]   trial;
        logic [fccp_pkg::ROOT_REM_W+1:0]   diff;
        logic                              fits;

        if (k == 0)
        begin : g_first
            assign valid_in = valid_e_reg;
            assign ctx_in   = ctx_e_reg;
            assign rem_in   = '0;
            assign root_in  = '0;
            assign x_in     = ctx_e_reg.mrn;
        end
        else
        begin : g_rest
            assign valid_in = rt_valid_reg[k];
            assign ctx_in   = rt_ctx_reg[k];
            assign rem_in   = rt_rem_reg[k];
            assign root_in  = rt_root_reg[k];
            assign x_in     = rt_x_reg[k];
        end

        assign rem2  = {rem_in, x_in[fccp_pkg::MRN_W-1:fccp_pkg::MRN_W-2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign diff  = rem2 - trial;
        assign fits  = (rem2 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                rt_valid_reg[k+1] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_ctx_reg[k+1]  <= ctx_in;
                rt_rem_reg[k+1]  <= fits ? diff[fccp_pkg::ROOT_REM_W-1:0]
                                         : rem2[fccp_pkg::ROOT_REM_W-1:0];
                rt_root_reg[k+1] <= {root_in[fccp_pkg::ROOT_W-2:0], fits};
                rt_x_reg[k+1]    <= {x_in[fccp_pkg::MRN_W-3:0], 2'b00};
            end
        end
    end

    // Cone scale factor p * 2^16 / root. On a slipping contact it stays below
    // 2^34, so the dividend starts with its top bits already in the remainder.
    logic                           qd_valid_reg [1:fccp_pkg::SCALE_W];
    fccp_pkg::fccp_ctx_t            qd_ctx_reg   [1:fccp_pkg::SCALE_W];
    logic [fccp_pkg::ROOT_W-1:0]    qd_s_reg     [1:fccp_pkg::SCALE_W];
    logic [fccp_pkg::ROOT_W-1:0]    qd_rem_reg   [1:fccp_pkg::SCALE_W];
    logic [fccp_pkg::SCALE_W-1:0]   qd_dq_reg    [1:fccp_pkg::SCALE_W];

    for (genvar k = 0; k < fccp_pkg::SCALE_W; k++)
    begin : g_scale
        logic                          valid_in;
        fccp_pkg::fccp_ctx_t           ctx_in;
        logic [fccp_pkg::ROOT_W-1:0]   s_in;
        logic [fccp_pkg::ROOT_W-1:0]   rem_in;
        logic [fccp_pkg::SCALE_W-1:0]  dq_in;
        logic [fccp_pkg::ROOT_W:0]     trial;
        logic [fccp_pkg::ROOT_W:0]     diff;
        logic                          fits;

        if (k == 0)
        begin : g_first
            assign valid_in = rt_valid_reg[fccp_pkg::ROOT_W];
            assign ctx_in   = rt_ctx_reg[fccp_pkg::ROOT_W];
            assign s_in     = rt_root_reg[fccp_pkg::ROOT_W];
            assign rem_in   = rt_ctx_reg[fccp_pkg::ROOT_W].p[
                fccp_pkg::SCALE_SPLIT+fccp_pkg::ROOT_W-1:fccp_pkg::SCALE_SPLIT];
            assign dq_in    = {rt_ctx_reg[fccp_pkg::ROOT_W].p[fccp_pkg::SCALE_SPLIT-1:0],
                               {fccp_pkg::FRAC_W{1'b0}}};
        end
        else
        begin : g_rest
            assign valid_in = qd_valid_reg[k];
            assign ctx_in   = qd_ctx_reg[k];
            assign s_in     = qd_s_reg[k];
            assign rem_in   = qd_rem_reg[k];
            assign dq_in    = qd_dq_reg[k];
        end

        assign trial = {rem_in, dq_in[fccp_pkg::SCALE_W-1]};
        assign diff  = trial - {1'b0, s_in};
        assign fits  = (trial >= {1'b0, s_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                qd_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                qd_valid_reg[k+1] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                qd_ctx_reg[k+1] <= ctx_in;
                qd_s_reg[k+1]   <= s_in;
                qd_rem_reg[k+1] <= fits ? diff[fccp_pkg::ROOT_W-1:0]
                                        : trial[fccp_pkg::ROOT_W-1:0];
                qd_dq_reg[k+1]  <= {dq_in[fccp_pkg::SCALE_W-2:0], fits};
            end
        end
    end

    // Tangential scaling and the result register.
    fccp_pkg::fccp_ctx_t             ctx_f_reg;
    logic                            valid_f_reg;
    logic [fccp_pkg::SCALED_W-1:0]   prod_a_next, prod_a_reg, prod_b_next, prod_b_reg;
    logic                            out_valid_reg;
    logic [fccp_pkg::DATA_W-1:0]     force_n_next, force_n_reg;
    logic [fccp_pkg::DATA_W-1:0]     force_a_next, force_a_reg;
    logic [fccp_pkg::DATA_W-1:0]     force_b_next, force_b_reg;
    fccp_pkg::fccp_mode_t            mode_next, mode_reg;
    logic                            bad_reg;

    assign prod_a_next = qd_ctx_reg[fccp_pkg::SCALE_W].mag_a * qd_dq_reg[fccp_pkg::SCALE_W];
    assign prod_b_next = qd_ctx_reg[fccp_pkg::SCALE_W].mag_b * qd_dq_reg[fccp_pkg::SCALE_W];

    always_comb
    begin
        force_n_next = '0;
        force_a_next = '0;
        force_b_next = '0;
        mode_next    = fccp_pkg::MODE_SEPARATED;
        if (!ctx_f_reg.drop)
        begin
            force_n_next = {1'b0, ctx_f_reg.z_n};
            if (ctx_f_reg.slip)
            begin
                force_a_next = sat_pack(ctx_f_reg.neg_a,
                                        prod_a_reg[fccp_pkg::SCALED_W-1:fccp_pkg::DATA_W]);
                force_b_next = sat_pack(ctx_f_reg.neg_b,
                                        prod_b_reg[fccp_pkg::SCALED_W-1:fccp_pkg::DATA_W]);
                mode_next    = fccp_pkg::MODE_SLIP;
            end
            else
            begin
                force_a_next = sat_pack(ctx_f_reg.neg_a, {2'b00, ctx_f_reg.mag_a});
                force_b_next = sat_pack(ctx_f_reg.neg_b, {2'b00, ctx_f_reg.mag_b});
                mode_next    = fccp_pkg::MODE_STICK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_f_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_f_reg   <= qd_valid_reg[fccp_pkg::SCALE_W];
            out_valid_reg <= valid_f_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_f_reg   <= qd_ctx_reg[fccp_pkg::SCALE_W];
            prod_a_reg  <= prod_a_next;
            prod_b_reg  <= prod_b_next;
            force_n_reg <= force_n_next;
            force_a_reg <= force_a_next;
            force_b_reg <= force_b_next;
            mode_reg    <= mode_next;
            bad_reg     <= ctx_f_reg.bad;
        end
    end

    assign out_valid       = out_valid_reg;
    assign force_normal    = force_n_reg;
    assign force_tangent_a = force_a_reg;
    assign force_tangent_b = force_b_reg;
    assign contact_mode    = mode_reg;
    assign bad_diagonal    = bad_reg;

endmodule

`default_nettype wire

// ===== rtl/core/friction_cone_contact_projection.sv =====
// Projection of one frictional contact onto the friction cone, Q16.16.
// Input channel (in_valid / in_ready): one contact per transfer, carrying the
// normal and two tangential right-hand-side values and the three diagonal
// entries. Output channel (out_valid / out_ready): one result per contact, in
// order: three saturated forces, the contact mode and the bad-diagonal flag.
// Configuration channel (cfg_valid / cfg_ready): each transfer writes the
// friction coefficient; it is always ready and is meant to be written while
// no contact is in flight.
// One contact is taken every cycle while the receiver keeps up. The latency is
// set by the back pipeline: a 48-stage long division for the three forces, a
// 32-stage square root of the tangential norm and a 34-stage division for the
// cone scale factor, one result bit per stage, plus the product stages.
// When the receiver stalls, the result register holds and the whole back
// pipeline freezes; a four-entry queue behind the front end absorbs further
// input, and in_ready falls only once that queue is full.
// Reset empties the queue and the pipeline and sets the coefficient to zero.
`timescale 1ns / 1ps
`default_nettype none

module friction_cone_contact_projection (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fccp_pkg::COEF_W-1:0]         friction_coef,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [fccp_pkg::DATA_W-1:0]  rhs_normal,
    input  logic signed [fccp_pkg::DATA_W-1:0]  rhs_tangent_a,
    input  logic signed [fccp_pkg::DATA_W-1:0]  rhs_tangent_b,
    input  logic signed [fccp_pkg::DATA_W-1:0]  diag_normal,
    input  logic signed [fccp_pkg::DATA_W-1:0]  diag_tangent_a,
    input  logic signed [fccp_pkg::DATA_W-1:0]  diag_tangent_b,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [fccp_pkg::DATA_W-1:0]  force_normal,
    output logic signed [fccp_pkg::DATA_W-1:0]  force_tangent_a,
    output logic signed [fccp_pkg::DATA_W-1:0]  force_tangent_b,
    output logic [1:0]                          contact_mode,
    output logic                                bad_diagonal
);

    // Friction coefficient, taken on every configuration transfer.
    logic [fccp_pkg::COEF_W-1:0] coef_reg;

    logic                  queue_full;
    logic                  queue_empty;
    logic                  push;
    logic                  pop;
    fccp_pkg::fccp_item_t  push_item;
    fccp_pkg::fccp_item_t  head_item;
    fccp_pkg::fccp_mode_t  mode;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_valid)
        begin
            coef_reg <= friction_coef;
        end
    end

    // The front end classifies each contact as separated, badly conditioned
    // or live, and prepares magnitudes and divisors for the back pipeline.
    fccp_front u_front (
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rhs_normal     (rhs_normal),
        .rhs_tangent_a  (rhs_tangent_a),
        .rhs_tangent_b  (rhs_tangent_b),
        .diag_normal    (diag_normal),
        .diag_tangent_a (diag_tangent_a),
        .diag_tangent_b (diag_tangent_b),
        .queue_full     (queue_full),
        .push           (push),
        .push_item      (push_item)
    );

    // The queue decouples the two halves, so that each can stall on its own.
    fccp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .empty     (queue_empty),
        .head_item (head_item)
    );

    // The back pipeline does the divisions, the cone test and the scaling.
    fccp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .coef            (coef_reg),
        .queue_empty     (queue_empty),
        .head_item       (head_item),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .force_normal    (force_normal),
        .force_tangent_a (force_tangent_a),
        .force_tangent_b (force_tangent_b),
        .contact_mode    (mode),
        .bad_diagonal    (bad_diagonal)
    );

    assign contact_mode = mode;

    // A separated or rejected contact carries no force at all.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mode == fccp_pkg::MODE_SEPARATED)
        |-> (force_normal == '0) && (force_tangent_a == '0) && (force_tangent_b == '0))
    else $error("separated contact with nonzero force");

    // A bad diagonal always reports the contact as separated.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_diagonal |-> (mode == fccp_pkg::MODE_SEPARATED))
    else $error("bad diagonal without separated mode");

    // The normal force is never negative.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !force_normal[fccp_pkg::DATA_W-1])
    else $error("negative normal force");

    // The queue is never written while full.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
    else $error("queue overflow");

endmodule

`default_nettype wire

// ===== tb/tb_friction_cone_contact_projection.sv =====
`timescale 1ns / 1ps

module tb_friction_cone_contact_projection;
    import fccp_pkg::*;

    // One contact as it is offered on the input channel.
    typedef struct {
        logic signed [DATA_W-1:0] b0, b1, b2, c0, c1, c2;
    } contact_t;

    // One result as it is expected on the output channel.
    typedef struct {
        logic signed [DATA_W-1:0] zn, za, zb;
        fccp_mode_t               mode;
        logic                     bad;
    } forces_t;

    // A row of the directed table: when known is set the result is typed in,
    // otherwise the predictor supplies it.
    typedef struct {
        contact_t c;
        logic     known;
        forces_t  f;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [COEF_W-1:0] friction_coef = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [DATA_W-1:0] rhs_normal = '0, rhs_tangent_a = '0, rhs_tangent_b = '0;
    logic signed [DATA_W-1:0] diag_normal = '0, diag_tangent_a = '0, diag_tangent_b = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [DATA_W-1:0] force_normal, force_tangent_a, force_tangent_b;
    logic [1:0] contact_mode;
    logic bad_diagonal;

    // The coefficient as the block holds it, and the forces still owed.
    logic [COEF_W-1:0] coef_now = '0;
    forces_t pending_forces[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit sender_bursting = 1'b0;

    localparam int LATENCY   = 121;
    localparam int IDLE_LIMIT = 4000;

    friction_cone_contact_projection dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .friction_coef(friction_coef),
        .in_valid(in_valid), .in_ready(in_ready),
        .rhs_normal(rhs_normal), .rhs_tangent_a(rhs_tangent_a),
        .rhs_tangent_b(rhs_tangent_b), .diag_normal(diag_normal),
        .diag_tangent_a(diag_tangent_a), .diag_tangent_b(diag_tangent_b),
        .out_valid(out_valid), .out_ready(out_ready),
        .force_normal(force_normal), .force_tangent_a(force_tangent_a),
        .force_tangent_b(force_tangent_b), .contact_mode(contact_mode),
        .bad_diagonal(bad_diagonal)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Clamp a sign and magnitude into the 32-bit two's complement range.
    function automatic logic [DATA_W-1:0] clamp32(bit neg, logic [63:0] mag);
        if (neg)
        begin
            if (mag > 64'h8000_0000)
                mag = 64'h8000_0000;
            return DATA_W'(64'd0 - mag);
        end
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return mag[DATA_W-1:0];
    endfunction

    // Minus b over c in Q16.16, truncated toward zero; c is known positive.
    function automatic logic [DATA_W-1:0] neg_quotient(logic signed [DATA_W-1:0] b,
                                                       logic signed [DATA_W-1:0] c);
        longint bb;
        logic [63:0] m;
        bb = b;
        m = (bb < 0) ? 64'(-bb) : 64'(bb);
        return clamp32(bb > 0, (m << FRAC_W) / {32'd0, c});
    endfunction

    // Scale one tangential force by the unsigned Q.32 cone factor; the product
    // is taken at 64 bits, while the block keeps a 66-bit product.
    function automatic logic [DATA_W-1:0] cone_scale(logic signed [DATA_W-1:0] z,
                                                     logic [63:0] q);
        longint zz;
        logic [63:0] m;
        logic [63:0] prod;
        zz = z;
        m = (zz < 0) ? 64'(-zz) : 64'(zz);
        prod = m * q;
        return clamp32(zz < 0, prod >> 32);
    endfunction

    // Expected projection of one contact under friction coefficient mu.
    function automatic forces_t project_contact(contact_t c, logic [COEF_W-1:0] mu);
        forces_t r;
        longint a1, a2;
        logic [63:0] mrn, p, x, root, bt, q;
        logic [127:0] lhs, rhs;
        r.zn = '0; r.za = '0; r.zb = '0; r.mode = MODE_SEPARATED; r.bad = 1'b0;
        if (c.b0 > 0)
            return r;
        if (c.c0 <= 0 || c.c1 <= 0 || c.c2 <= 0)
        begin
            r.bad = 1'b1;
            return r;
        end
        r.zn = neg_quotient(c.b0, c.c0);
        r.za = neg_quotient(c.b1, c.c1);
        r.zb = neg_quotient(c.b2, c.c2);
        a1 = r.za;
        a2 = r.zb;
        if (a1 < 0) a1 = -a1;
        if (a2 < 0) a2 = -a2;
        mrn = 64'(a1) * 64'(a1) + 64'(a2) * 64'(a2);
        p = {43'd0, mu} * {32'd0, r.zn};
        lhs = {mrn, 64'd0} >> 32;
        rhs = {64'd0, p} * {64'd0, p};
        if (lhs > rhs)
        begin
            // Integer square root of the tangential norm squared.
            x = mrn;
            root = 0;
            bt = 64'd1 << 62;
            while (bt > x)
                bt = bt >> 2;
            while (bt != 0)
            begin
                if (x >= root + bt)
                begin
                    x = x - (root + bt);
                    root = (root >> 1) + bt;
                end
                else
                    root = root >> 1;
                bt = bt >> 2;
            end
            q = (p << FRAC_W) / root;
            r.za = cone_scale(r.za, q);
            r.zb = cone_scale(r.zb, q);
            r.mode = MODE_SLIP;
        end
        else
            r.mode = MODE_STICK;
        return r;
    endfunction

    // Any transfer on either data channel keeps the watchdog quiet.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_coef(logic [COEF_W-1:0] v);
        cfg_valid <= 1'b1;
        friction_coef <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        coef_now = v;
        cfg_valid <= 1'b0;
    endtask

    // Offer one contact after a random gap, or none while bursting, and hold it until the transfer.
    task automatic offer_contact(contact_t c, bit known, forces_t f);
        int gap;
        gap = sender_bursting ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rhs_normal <= c.b0;
        rhs_tangent_a <= c.b1;
        rhs_tangent_b <= c.b2;
        diag_normal <= c.c0;
        diag_tangent_a <= c.c1;
        diag_tangent_b <= c.c2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_forces.push_back(known ? f : project_contact(c, coef_now));
    endtask

    // Wait until every owed result has come back and the pipeline is drained.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_forces.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // Random contact, mostly compressive with sensible diagonals so that the
    // cone test is reached; the others are raw noise over every bit, separated, or carry a bad diagonal.
    function automatic contact_t random_contact;
        contact_t c;
        int kind;
        kind = $urandom_range(0, 19);
        c.b0 = $urandom; c.b1 = $urandom; c.b2 = $urandom;
        c.c0 = $urandom; c.c1 = $urandom; c.c2 = $urandom;
        if (kind < 2)
            return c;
        c.b0 = -$signed(32'($urandom_range(0, 32'h0010_0000)));
        if (kind < 6)
            c.b0 = -$signed({1'b0, 31'($urandom)});
        c.b1 = $signed(32'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
        c.b2 = $signed(32'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
        if (kind == 6)
            c.b1 = $urandom;
        c.c0 = $urandom_range(1, 32'h0004_0000);
        c.c1 = $urandom_range(1, 32'h0004_0000);
        c.c2 = $urandom_range(1, 32'h0004_0000);
        if (kind == 7)
            c.c1 = $urandom_range(1, 32'h7FFF_FFFF);
        if (kind == 8)
            c.c2 = -$signed(32'($urandom_range(0, 100)));
        if (kind == 9)
            c.b0 = $urandom_range(1, 32'h7FFF_FFFF);
        return c;
    endfunction

    function automatic bit field_ok(string name, logic [DATA_W-1:0] exp_v,
                                    logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %h, got %h", $realtime, name, exp_v, act_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Receiver: stall at random, then compare each transfer with the oldest
    // expectation, field by field.
    initial
    begin
        forces_t e;
        int stall;
        bit ok;
        @(posedge rst_n);
        forever
        begin
            stall = sender_bursting ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_forces.size() == 0)
            begin
                $display("%0t: result with none expected, got %h %h %h", $realtime,
                         force_normal, force_tangent_a, force_tangent_b);
                mismatches++;
            end
            else
            begin
                e = pending_forces.pop_front();
                ok = field_ok("force_normal", e.zn, force_normal);
                ok &= field_ok("force_tangent_a", e.za, force_tangent_a);
                ok &= field_ok("force_tangent_b", e.zb, force_tangent_b);
                ok &= field_ok("contact_mode", 32'(e.mode), 32'(contact_mode));
                ok &= field_ok("bad_diagonal", 32'(e.bad), 32'(bad_diagonal));
                if (!ok)
                    mismatches++;
            end
        end
    end

    initial
    begin
        row_t rows[$];
        row_t r;
        forces_t none;
        logic [COEF_W-1:0] coefs[5];
        none.zn = '0; none.za = '0; none.zb = '0;
        none.mode = MODE_SEPARATED; none.bad = 1'b0;
        coefs = '{21'h01_0000, 21'h10_0000, 21'h1F_FFFF, 21'd0, 21'h00_8000};

        // Separated contact: forces zero, diagonals ignored even if bad.
        r.known = 1'b1; r.f = none;
        r.c = '{32'sd1, 32'sh7FFF_FFFF, -32'sh8000_0000, -32'sd5, 32'sd0, 32'sd0};
        rows.push_back(r);
        r.c = '{32'sh7FFF_FFFF, 32'sd7, 32'sd7, -32'sh8000_0000, -32'sd1, 32'sd0};
        rows.push_back(r);
        // Bad diagonal on each lane.
        r.f.bad = 1'b1;
        r.c = '{-32'sh0001_0000, 32'sd3, 32'sd3, 32'sd0, 32'sh10000, 32'sh10000};
        rows.push_back(r);
        r.c = '{32'sd0, 32'sd3, 32'sd3, 32'sh10000, -32'sd1, 32'sh10000};
        rows.push_back(r);
        r.c = '{-32'sh8000_0000, 32'sd3, 32'sd3, 32'sh10000, 32'sh10000,
                -32'sh8000_0000};
        rows.push_back(r);
        // All-zero right-hand side sticks with zero forces.
        r.f = none; r.f.mode = MODE_STICK;
        r.c = '{32'sd0, 32'sd0, 32'sd0, 32'sh10000, 32'sh10000, 32'sh10000};
        rows.push_back(r);
        // Most negative normal value over the smallest diagonal saturates.
        r.f.zn = 32'sh7FFF_FFFF;
        r.c = '{-32'sh8000_0000, 32'sd0, 32'sd0, 32'sd1, 32'sh7FFF_FFFF, 32'sd1};
        rows.push_back(r);
        // The rest go through the predictor.
        r.known = 1'b0;
        r.c = '{-32'sh0001_0000, 32'sh0001_0000, 32'sd0, 32'sh10000, 32'sh10000,
                32'sh10000};
        rows.push_back(r);
        r.c = '{32'sd0, 32'sd100, -32'sd100, 32'sh10000, 32'sh10000, 32'sh10000};
        rows.push_back(r);
        r.c = '{-32'sh0002_0000, -32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh10000, 32'sd1,
                32'sd1};
        rows.push_back(r);
        r.c = '{-32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        rows.push_back(r);
        r.c = '{-32'sh0003_0000, 32'sh0000_8000, 32'sh0000_8000, 32'sh10000,
                32'sh10000, 32'sh10000};
        rows.push_back(r);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows run at the reset coefficient and then at unity, where
        // the cone test has a real edge.
        foreach (rows[i])
            offer_contact(rows[i].c, rows[i].known, rows[i].f);
        drain();
        write_coef(21'h01_0000);
        foreach (rows[i])
            offer_contact(rows[i].c, 1'b0, none);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_coef(ph < 5 ? coefs[ph] : 21'($urandom));
            for (int n = 0; n < 180; n++)
            begin
                if (n % 60 == 0)
                    sender_bursting = ($urandom_range(0, 2) == 0);
                offer_contact(random_contact(), 1'b0, none);
            end
            sender_bursting = 1'b0;
            drain();
        end

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
